FILE: rtl/core/assert_macros.svh
// assertion macros shared by the rtl of the quad vertex expander
// no dependencies; synthesis builds see empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define AQVE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true outside reset
`define AQVE_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define AQVE_ASSERT(lbl, clk, rst_n, prop, msg)
`define AQVE_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

FILE: rtl/core/aqve_pkg.sv
// shared types, constants and helpers of the quad vertex expander
// no dependencies
`default_nettype none

package aqve_pkg;

	localparam int COORD_W      = 32;
	localparam int SCALE_W      = 24;
	localparam int SCALE_FRAC   = 16;
	localparam int ANCHOR_W     = 16;
	localparam int ANCHOR_ONE   = 16384;
	localparam int ANCHOR_SHIFT = 15;
	localparam int UV_W         = 17;
	localparam int UV_ONE       = 65536;

	// scaled coordinate, anchored offset and corner sum widths
	localparam int EXT_W  = 41;
	localparam int AM_W   = 17;
	localparam int PROD_W = 58;
	localparam int OFF_W  = 43;
	localparam int SUM_W  = 45;

	localparam int VERTS  = 6;
	localparam int VIDX_W = 3;
	// bit j set: vertex j takes the high corner
	localparam logic [VERTS-1:0] HI_X_MASK = 6'b101100;
	localparam logic [VERTS-1:0] HI_Y_MASK = 6'b110010;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_SPACE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_USE_ANCHOR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_USE_TEX_RECT = 3'd4;

	localparam int QUEUE_DEPTH_DEF = 4;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [UV_W-1:0] uv_t;

	typedef struct packed {
		coord_t                      pos_x;
		coord_t                      pos_y;
		coord_t                      pos_z;
		coord_t                      width;
		coord_t                      height;
		logic signed [ANCHOR_W-1:0]  anchor_x;
		logic signed [ANCHOR_W-1:0]  anchor_y;
		uv_t                         tex_u0;
		uv_t                         tex_v0;
		uv_t                         tex_u1;
		uv_t                         tex_v1;
		logic                        last_item;
	} rect_in_t;

	typedef struct packed {
		coord_t vert_x;
		coord_t vert_y;
		coord_t vert_z;
		uv_t    tex_u;
		uv_t    tex_v;
		logic   last_of_quad;
		logic   last_of_batch;
	} vert_out_t;

	// one rectangle ready for expansion
	typedef struct packed {
		coord_t x0;
		coord_t x1;
		coord_t y0;
		coord_t y1;
		coord_t z;
		uv_t    u0;
		uv_t    u1;
		uv_t    v0;
		uv_t    v1;
		logic   last;
	} rect_rec_t;

	function automatic coord_t sat_coord(input logic signed [SUM_W-1:0] v);
		logic [SUM_W-COORD_W:0] hi_bits;
		hi_bits = v[SUM_W-1:COORD_W-1];
		if (hi_bits == '0 || hi_bits == '1) begin
			return v[COORD_W-1:0];
		end else if (v[SUM_W-1]) begin
			return {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			return {1'b0, {(COORD_W-1){1'b1}}};
		end
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/aqve_stream_if.sv
// valid/ready stream channel used for rectangles and vertices
// payload type is given by the instantiating level
`default_nettype none

interface aqve_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/aqve_front.sv
// front end: config registers and three-stage corner computation per rectangle
// depends on aqve_pkg and aqve_stream_if
`default_nettype none

module aqve_front import aqve_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	aqve_stream_if.sink           rect,
	output logic                  rec_valid,
	input  logic                  rec_ready,
	output rect_rec_t             rec
);

	typedef struct packed {
		coord_t z;
		uv_t    u0;
		uv_t    u1;
		uv_t    v0;
		uv_t    v1;
		logic   last;
	} side_t;

	logic               pixel_space_q;
	logic [SCALE_W-1:0] scale_x_q;
	logic [SCALE_W-1:0] scale_y_q;
	logic               use_anchor_q;
	logic               use_tex_rect_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_space_q  <= 1'b0;
			scale_x_q      <= SCALE_W'(UV_ONE);
			scale_y_q      <= SCALE_W'(UV_ONE);
			use_anchor_q   <= 1'b0;
			use_tex_rect_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PIXEL_SPACE:  pixel_space_q  <= cfg_data[0];
				CFG_SCALE_X:      scale_x_q      <= cfg_data[SCALE_W-1:0];
				CFG_SCALE_Y:      scale_y_q      <= cfg_data[SCALE_W-1:0];
				CFG_USE_ANCHOR:   use_anchor_q   <= cfg_data[0];
				CFG_USE_TEX_RECT: use_tex_rect_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stage handshake
	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;

	assign rdy3       = !v_s3 || rec_ready;
	assign rdy2       = !v_s2 || rdy3;
	assign rdy1       = !v_s1 || rdy2;
	assign rect.ready = rdy1;
	assign rec_valid  = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= rect.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	// stage 1: scale products, anchor term, texture select
	logic [SCALE_W:0]          sx, sy;
	logic signed [PROD_W-1:0]  prod_px, prod_ex, prod_py, prod_ey;
	logic signed [AM_W-1:0]    am_x, am_y;
	side_t                     side_in;

	always_comb begin
		sx = (SCALE_W+1)'(UV_ONE);
		sy = (SCALE_W+1)'(UV_ONE);
		if (pixel_space_q) begin
			if (scale_x_q != '0) sx = {1'b0, scale_x_q};
			if (scale_y_q != '0) sy = {1'b0, scale_y_q};
		end
		prod_px = PROD_W'(rect.data.pos_x) * PROD_W'($signed({1'b0, sx}))
			+ PROD_W'(1 << (SCALE_FRAC - 1));
		prod_ex = PROD_W'(rect.data.width) * PROD_W'($signed({1'b0, sx}))
			+ PROD_W'(1 << (SCALE_FRAC - 1));
		prod_py = PROD_W'(rect.data.pos_y) * PROD_W'($signed({1'b0, sy}))
			+ PROD_W'(1 << (SCALE_FRAC - 1));
		prod_ey = PROD_W'(rect.data.height) * PROD_W'($signed({1'b0, sy}))
			+ PROD_W'(1 << (SCALE_FRAC - 1));
		am_x = AM_W'(ANCHOR_ONE);
		am_y = AM_W'(ANCHOR_ONE);
		if (use_anchor_q) begin
			am_x = AM_W'(rect.data.anchor_x) + AM_W'(ANCHOR_ONE);
			am_y = AM_W'(rect.data.anchor_y) + AM_W'(ANCHOR_ONE);
		end
		side_in.z    = rect.data.pos_z;
		side_in.last = rect.data.last_item;
		if (use_tex_rect_q) begin
			side_in.u0 = rect.data.tex_u0;
			side_in.v0 = rect.data.tex_v0;
			side_in.u1 = rect.data.tex_u1;
			side_in.v1 = rect.data.tex_v1;
		end else begin
			side_in.u0 = '0;
			side_in.v0 = '0;
			side_in.u1 = UV_W'(UV_ONE);
			side_in.v1 = UV_W'(UV_ONE);
		end
	end

	logic signed [EXT_W-1:0] px_s1, ex_s1, py_s1, ey_s1;
	logic signed [AM_W-1:0]  amx_s1, amy_s1;
	side_t                   side_s1;

	always_ff @(posedge clk) begin
		if (rdy1 && rect.valid) begin
			px_s1   <= prod_px[SCALE_FRAC +: EXT_W];
			ex_s1   <= prod_ex[SCALE_FRAC +: EXT_W];
			py_s1   <= prod_py[SCALE_FRAC +: EXT_W];
			ey_s1   <= prod_ey[SCALE_FRAC +: EXT_W];
			amx_s1  <= am_x;
			amy_s1  <= am_y;
			side_s1 <= side_in;
		end
	end

	// stage 2: anchor offset (a+1)*e/2, rounded
	logic signed [PROD_W-1:0] offp_x, offp_y;

	assign offp_x = PROD_W'(amx_s1) * PROD_W'(ex_s1) + PROD_W'(1 << (ANCHOR_SHIFT - 1));
	assign offp_y = PROD_W'(amy_s1) * PROD_W'(ey_s1) + PROD_W'(1 << (ANCHOR_SHIFT - 1));

	logic signed [EXT_W-1:0] px_s2, ex_s2, py_s2, ey_s2;
	logic signed [OFF_W-1:0] offx_s2, offy_s2;
	side_t                   side_s2;

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			px_s2   <= px_s1;
			ex_s2   <= ex_s1;
			py_s2   <= py_s1;
			ey_s2   <= ey_s1;
			offx_s2 <= offp_x[ANCHOR_SHIFT +: OFF_W];
			offy_s2 <= offp_y[ANCHOR_SHIFT +: OFF_W];
			side_s2 <= side_s1;
		end
	end

	// stage 3: low and high corners, full width
	logic signed [SUM_W-1:0] lox_s3, hix_s3, loy_s3, hiy_s3;
	side_t                   side_s3;

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			lox_s3  <= SUM_W'(px_s2) - SUM_W'(offx_s2);
			hix_s3  <= SUM_W'(px_s2) + SUM_W'(ex_s2) - SUM_W'(offx_s2);
			loy_s3  <= SUM_W'(py_s2) - SUM_W'(offy_s2);
			hiy_s3  <= SUM_W'(py_s2) + SUM_W'(ey_s2) - SUM_W'(offy_s2);
			side_s3 <= side_s2;
		end
	end

	always_comb begin
		rec.x0   = sat_coord(lox_s3);
		rec.x1   = sat_coord(hix_s3);
		rec.y0   = sat_coord(loy_s3);
		rec.y1   = sat_coord(hiy_s3);
		rec.z    = side_s3.z;
		rec.u0   = side_s3.u0;
		rec.u1   = side_s3.u1;
		rec.v0   = side_s3.v0;
		rec.v1   = side_s3.v1;
		rec.last = side_s3.last;
	end

endmodule

`default_nettype wire

FILE: rtl/core/aqve_queue.sv
// short rectangle queue between front end and vertex emitter
// depends on aqve_pkg
`default_nettype none

module aqve_queue import aqve_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  rect_rec_t     push_data,
	output logic          head_valid,
	output rect_rec_t     head_data,
	input  logic          pop,
	output logic [CW-1:0] count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	rect_rec_t         entries_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              push;

	assign push_ready = count_q != CW'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_data  = entries_q[rd_ptr_q];
	assign count      = count_q;
	assign push       = push_valid && push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/aqve_emit.sv
// back end: walks the head rectangle through its six vertices into an output register
// depends on aqve_pkg and aqve_stream_if
`default_nettype none

module aqve_emit import aqve_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         head_valid,
	input  rect_rec_t    head,
	output logic         pop,
	aqve_stream_if.source vert
);

	logic              out_valid_q;
	vert_out_t         out_q;
	logic [VIDX_W-1:0] vidx_q;
	logic              load;
	logic              last_vert;
	vert_out_t         nxt;

	assign load       = !out_valid_q || vert.ready;
	assign last_vert  = vidx_q == VIDX_W'(VERTS - 1);
	assign pop        = load && head_valid && last_vert;
	assign vert.valid = out_valid_q;
	assign vert.data  = out_q;

	always_comb begin
		nxt.vert_x        = HI_X_MASK[vidx_q] ? head.x1 : head.x0;
		nxt.vert_y        = HI_Y_MASK[vidx_q] ? head.y1 : head.y0;
		nxt.vert_z        = head.z;
		nxt.tex_u         = HI_X_MASK[vidx_q] ? head.u1 : head.u0;
		nxt.tex_v         = HI_Y_MASK[vidx_q] ? head.v1 : head.v0;
		nxt.last_of_quad  = last_vert;
		nxt.last_of_batch = last_vert && head.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			vidx_q      <= '0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				vidx_q <= last_vert ? '0 : vidx_q + VIDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			out_q <= nxt;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/anchored_quad_vertex_expander_core.sv
// Anchored quad vertex expander.
// Channel rect (sink) takes one rectangle a beat: position, depth, extent, anchor,
// texture bounds and a batch-end mark. Channel vert (source) gives six vertex beats
// per rectangle in triangle order (x0,y0) (x0,y1) (x1,y0) (x1,y0) (x0,y1) (x1,y1);
// the sixth carries last_of_quad, and last_of_batch when the rectangle ended a batch.
// The config port writes one register at a clock edge with cfg_we high. The user must
// see that it is written only while no rectangle is in flight; the block does not
// enforce it. A rectangle passes front-end stage registers s1, s2 and s3, the queue
// and the vertex output register before its first vertex is valid.
// Throughput: one vertex per cycle while vert is ready and the queue holds a rectangle,
// set by the single vertex output register. The front end computes corners in 3 stages
// and keeps accepting while up to QUEUE_DEPTH finished rectangles wait for the emitter.
// Reset (arst_n low) empties the pipeline and queue and restores the register
// defaults: no pixel scaling, unit scales, no anchor, full 0..1 texture range.
// When vert is stalled the current vertex holds; the queue then fills and rect.ready
// drops after 3 + QUEUE_DEPTH rectangles are held.
`default_nettype none
`include "assert_macros.svh"

module anchored_quad_vertex_expander_core import aqve_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	aqve_stream_if.sink           rect,
	aqve_stream_if.source         vert
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic          rec_valid, rec_ready;
	rect_rec_t     rec;
	logic          q_head_valid;
	rect_rec_t     q_head;
	logic          q_pop;
	logic [CW-1:0] q_count;
	logic          q_push;
	logic          q_only_push, q_only_pop;
	logic [CW-1:0] q_count_up, q_count_dn;
	logic          bad_batch_mark;

	assign q_push = rec_valid && rec_ready;

	aqve_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rect      (rect),
		.rec_valid (rec_valid),
		.rec_ready (rec_ready),
		.rec       (rec)
	);

	aqve_queue #(
		.DEPTH (QUEUE_DEPTH),
		.CW    (CW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (rec_valid),
		.push_ready (rec_ready),
		.push_data  (rec),
		.head_valid (q_head_valid),
		.head_data  (q_head),
		.pop        (q_pop),
		.count      (q_count)
	);

	aqve_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head       (q_head),
		.pop        (q_pop),
		.vert       (vert)
	);

	assign q_only_push    = q_push && !q_pop;
	assign q_only_pop     = q_pop && !q_push;
	assign q_count_up     = q_count + CW'(1);
	assign q_count_dn     = q_count - CW'(1);
	assign bad_batch_mark = vert.valid && vert.data.last_of_batch && !vert.data.last_of_quad;

	`AQVE_NEVER(a_batch_mark, clk, arst_n, bad_batch_mark, "batch end outside quad end")
	`AQVE_NEVER(a_pop_empty, clk, arst_n, q_pop && !q_head_valid, "queue popped while empty")
	`AQVE_ASSERT(a_count_up, clk, arst_n, q_only_push |=> q_count == $past(q_count_up), "missed push")
	`AQVE_ASSERT(a_count_down, clk, arst_n, q_only_pop |=> q_count == $past(q_count_dn), "missed pop")

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// self-checking bench for anchored_quad_vertex_expander_core: offers rectangles, expands each
// into its six predicted vertices and checks every vertex beat in order
// depends on aqve_pkg, aqve_stream_if and the core rtl

module testbench;
	import aqve_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 6;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int TAIL_CYCLES  = 20;
	localparam int HOLD_CYCLES  = 400;
	localparam int PRINT_MAX    = 40;
	localparam int IDLE_HEAVY   = 82;
	localparam int IDLE_LIGHT   = 7;

	// bit j set: vertex j of the quad takes the high corner
	localparam logic [VERTS-1:0] X_HI = 6'b101100;
	localparam logic [VERTS-1:0] Y_HI = 6'b110010;

	localparam coord_t C_MAX = 32'sh7fff_ffff;
	localparam coord_t C_MIN = 32'sh8000_0000;
	localparam logic signed [ANCHOR_W-1:0] A_MAX = 16'sh7fff;
	localparam logic signed [ANCHOR_W-1:0] A_MIN = 16'sh8000;
	localparam uv_t UV_MAX = '1;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	aqve_stream_if #(.payload_t(rect_in_t))  rect_ch ();
	aqve_stream_if #(.payload_t(vert_out_t)) vert_ch ();

	anchored_quad_vertex_expander_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rect      (rect_ch),
		.vert      (vert_ch)
	);

	// shadow of the block's registers
	bit                 sh_pix = 1'b0;
	logic [SCALE_W-1:0] sh_sx  = 24'd65536;
	logic [SCALE_W-1:0] sh_sy  = 24'd65536;
	bit                 sh_anc = 1'b0;
	bit                 sh_tex = 1'b0;

	rect_in_t  rects_pending[$];
	vert_out_t verts_predicted[$];

	bit rect_taken;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_goal;
	int hold_count;
	int fail_count;
	int vert_count;
	int cycle_count;

	function automatic longint rnd_shr(longint v, int sh);
		// round to nearest, halves toward +inf
		return (v + (64'sd1 <<< (sh - 1))) >>> sh;
	endfunction

	function automatic coord_t clamp32(longint v);
		if (v > longint'(C_MAX)) begin
			return C_MAX;
		end
		if (v < longint'(C_MIN)) begin
			return C_MIN;
		end
		return coord_t'(v);
	endfunction

	function automatic void axis_corners(input coord_t p, input coord_t e, input longint a,
			input logic [SCALE_W-1:0] scl, output coord_t lo_c, output coord_t hi_c);
		longint pw;
		longint ew;
		longint s;
		longint lo;
		pw = longint'(p);
		ew = longint'(e);
		if (sh_pix) begin
			s = (scl == '0) ? longint'(1 << SCALE_FRAC) : longint'(scl);
			pw = rnd_shr(pw * s, SCALE_FRAC);
			ew = rnd_shr(ew * s, SCALE_FRAC);
		end
		lo = pw - rnd_shr((a + ANCHOR_ONE) * ew, ANCHOR_SHIFT);
		lo_c = clamp32(lo);
		hi_c = clamp32(lo + ew);
	endfunction

	function automatic void expand_quad(rect_in_t r);
		coord_t    x0, x1, y0, y1;
		uv_t       u0, u1, v0, v1;
		longint    ax, ay;
		vert_out_t v;
		ax = sh_anc ? longint'(r.anchor_x) : 64'sd0;
		ay = sh_anc ? longint'(r.anchor_y) : 64'sd0;
		axis_corners(r.pos_x, r.width, ax, sh_sx, x0, x1);
		axis_corners(r.pos_y, r.height, ay, sh_sy, y0, y1);
		if (sh_tex) begin
			u0 = r.tex_u0;
			v0 = r.tex_v0;
			u1 = r.tex_u1;
			v1 = r.tex_v1;
		end else begin
			u0 = '0;
			v0 = '0;
			u1 = uv_t'(UV_ONE);
			v1 = uv_t'(UV_ONE);
		end
		for (int j = 0; j < VERTS; j++) begin
			v.vert_x        = X_HI[j] ? x1 : x0;
			v.vert_y        = Y_HI[j] ? y1 : y0;
			v.vert_z        = r.pos_z;
			v.tex_u         = X_HI[j] ? u1 : u0;
			v.tex_v         = Y_HI[j] ? v1 : v0;
			v.last_of_quad  = (j == VERTS - 1);
			v.last_of_batch = (j == VERTS - 1) && r.last_item;
			verts_predicted.push_back(v);
		end
	endfunction

	function automatic rect_in_t mk_rect(coord_t px, coord_t py, coord_t pz, coord_t w,
			coord_t h, logic signed [ANCHOR_W-1:0] ax, logic signed [ANCHOR_W-1:0] ay,
			uv_t u0, uv_t v0, uv_t u1, uv_t v1, logic last);
		rect_in_t r;
		r.pos_x     = px;
		r.pos_y     = py;
		r.pos_z     = pz;
		r.width     = w;
		r.height    = h;
		r.anchor_x  = ax;
		r.anchor_y  = ay;
		r.tex_u0    = u0;
		r.tex_v0    = v0;
		r.tex_u1    = u1;
		r.tex_v1    = v1;
		r.last_item = last;
		return r;
	endfunction

	function automatic coord_t rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom) >>> $urandom_range(20, 30);
			default: return $signed($urandom) >>> $urandom_range(4, 19);
		endcase
	endfunction

	function automatic logic signed [ANCHOR_W-1:0] rand_anchor();
		int a;
		if ($urandom_range(4) == 0) begin
			a = $urandom;
		end else begin
			a = int'($urandom_range(2 * ANCHOR_ONE)) - ANCHOR_ONE;
		end
		return a[ANCHOR_W-1:0];
	endfunction

	function automatic rect_in_t rand_rect();
		return mk_rect(rand_coord(), rand_coord(), $urandom, rand_coord(), rand_coord(),
			rand_anchor(), rand_anchor(), uv_t'($urandom), uv_t'($urandom),
			uv_t'($urandom), uv_t'($urandom), $urandom_range(3) == 0);
	endfunction

	task automatic check_field(string nm, logic [COORD_W-1:0] want, logic [COORD_W-1:0] got);
		if (want !== got) begin
			fail_count++;
			if (fail_count <= PRINT_MAX) begin
				$display("%0t ns: vertex %0d %s expected %h got %h",
					$time, vert_count, nm, want, got);
			end
		end
	endtask

	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (rects_pending.size() != 0 || verts_predicted.size() != 0 || rect_ch.valid);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_PIXEL_SPACE:  sh_pix = val[0];
			CFG_SCALE_X:      sh_sx = val[SCALE_W-1:0];
			CFG_SCALE_Y:      sh_sy = val[SCALE_W-1:0];
			CFG_USE_ANCHOR:   sh_anc = val[0];
			CFG_USE_TEX_RECT: sh_tex = val[0];
			default: ;
		endcase
	endtask

	task automatic cfg_release();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// one-bit registers get random upper bits, which the block must drop
	task automatic apply_settings(bit pix, logic [SCALE_W-1:0] sx, logic [SCALE_W-1:0] sy,
			bit anc, bit tex);
		wait_drained();
		cfg_write(CFG_PIXEL_SPACE, {(CFG_DATA_W-1)'($urandom), pix});
		cfg_write(CFG_SCALE_X, sx);
		cfg_write(CFG_SCALE_Y, sy);
		cfg_write(CFG_USE_ANCHOR, {(CFG_DATA_W-1)'($urandom), anc});
		cfg_write(CFG_USE_TEX_RECT, {(CFG_DATA_W-1)'($urandom), tex});
		cfg_release();
	endtask

	task automatic set_idle(int sp, int rp);
		send_idle_pct  = sp;
		recv_stall_pct = rp;
	endtask

	task automatic push_random(int n);
		repeat (n) rects_pending.push_back(rand_rect());
	endtask

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// acceptance of rectangle beats feeds the predictor
	always @(posedge clk) begin
		rect_taken <= arst_n && rect_ch.valid && rect_ch.ready;
		if (arst_n && rect_ch.valid && rect_ch.ready) begin
			expand_quad(rect_ch.data);
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			rect_ch.valid <= 1'b0;
		end else if (!rect_ch.valid || rect_taken) begin
			if (rects_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				rect_ch.valid <= 1'b1;
				rect_ch.data  <= rects_pending.pop_front();
			end else begin
				rect_ch.valid <= 1'b0;
			end
		end
	end

	// receiver: long hold-off when requested, otherwise random stalls
	always @(negedge clk) begin
		if (hold_count < hold_goal) begin
			vert_ch.ready <= 1'b0;
			hold_count    <= hold_count + 1;
		end else begin
			vert_ch.ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : vertex_check
		vert_out_t want;
		if (arst_n && vert_ch.valid && vert_ch.ready) begin
			if (verts_predicted.size() == 0) begin
				fail_count++;
				if (fail_count <= PRINT_MAX) begin
					$display("%0t ns: vertex beat with nothing expected: x %h y %h z %h",
						$time, vert_ch.data.vert_x, vert_ch.data.vert_y, vert_ch.data.vert_z);
				end
			end else begin
				want = verts_predicted.pop_front();
				check_field("vert_x", want.vert_x, vert_ch.data.vert_x);
				check_field("vert_y", want.vert_y, vert_ch.data.vert_y);
				check_field("vert_z", want.vert_z, vert_ch.data.vert_z);
				check_field("tex_u", COORD_W'(want.tex_u), COORD_W'(vert_ch.data.tex_u));
				check_field("tex_v", COORD_W'(want.tex_v), COORD_W'(vert_ch.data.tex_v));
				check_field("last_of_quad", COORD_W'(want.last_of_quad),
					COORD_W'(vert_ch.data.last_of_quad));
				check_field("last_of_batch", COORD_W'(want.last_of_batch),
					COORD_W'(vert_ch.data.last_of_batch));
			end
			vert_count++;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** anchored_quad_vertex_expander_core: FAILED **");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		rect_ch.valid = 1'b0;
		rect_ch.data  = '0;
		vert_ch.ready = 1'b0;
		set_idle(0, 0);
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset defaults: anchor and texture fields must be ignored
		rects_pending.push_back(mk_rect(C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, A_MAX, A_MIN,
			UV_MAX, UV_MAX, 0, 0, 1));
		rects_pending.push_back(mk_rect(C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, A_MIN, A_MAX,
			0, 0, UV_MAX, UV_MAX, 0));
		rects_pending.push_back(mk_rect(1, -1, 0, 1, -1, 0, 0, 0, 0, 0, 0, 1));
		rects_pending.push_back(mk_rect(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

		// largest x scale, zero y scale, plus writes to unused indexes
		apply_settings(1'b1, '1, '0, 1'b1, 1'b1);
		for (int k = int'(CFG_USE_TEX_RECT) + 1; k < (1 << CFG_IDX_W); k++) begin
			cfg_write(k[CFG_IDX_W-1:0], CFG_DATA_W'($urandom));
		end
		cfg_release();
		rects_pending.push_back(mk_rect(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, A_MAX, A_MAX,
			UV_MAX, UV_MAX, UV_MAX, UV_MAX, 1));
		rects_pending.push_back(mk_rect(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, A_MIN, A_MIN,
			0, 0, 0, 0, 0));
		// reversed texture bounds
		rects_pending.push_back(mk_rect(C_MAX, C_MIN, 0, C_MIN, C_MAX, -16384, 16384,
			UV_MAX, 0, 0, UV_MAX, 1));
		rects_pending.push_back(mk_rect(1, -1, 5, 1, -1, 16384, -16384, 1, 2, 3, 4, 0));
		rects_pending.push_back(mk_rect(-1, 1, -5, -3, 3, 0, 0, 0, UV_MAX, UV_MAX, 0, 1));
		rects_pending.push_back(mk_rect(0, 0, 0, 0, 0, A_MAX, A_MIN, 0, 0, 0, 0, 0));

		// half and one-and-a-half scales put products exactly on rounding halves
		apply_settings(1'b1, 24'd32768, 24'd98304, 1'b1, 1'b0);
		rects_pending.push_back(mk_rect(1, 3, 7, 1, 3, 0, 0, 0, 0, 0, 0, 0));
		rects_pending.push_back(mk_rect(-1, -3, 0, -1, -3, 8192, -8192, 0, 0, 0, 0, 1));
		rects_pending.push_back(mk_rect(32'sh0000_ffff, -32'sh0001_0001, 9, 3, -5,
			-8192, 8192, 0, 0, 0, 0, 0));

		// scales set but ignored outside pixel space
		apply_settings(1'b0, 24'd3, '1, 1'b1, 1'b0);
		push_random(60);

		apply_settings(1'b1, '0, 24'd65536, 1'b0, 1'b1);
		set_idle(IDLE_HEAVY, 0);
		push_random(60);

		apply_settings(1'b1, SCALE_W'($urandom_range(24'hffffff)),
			SCALE_W'($urandom_range(24'hffffff)), 1'b1, 1'b1);
		set_idle(0, IDLE_HEAVY);
		push_random(60);

		apply_settings(1'b1, '1, '1, 1'b1, 1'b1);
		set_idle(IDLE_LIGHT, IDLE_LIGHT);
		push_random(60);

		// receiver holds off while rectangles keep coming, so the input backs up
		apply_settings(1'b1, 24'd1, 24'd2, 1'b1, 1'b0);
		set_idle(0, 0);
		hold_goal = hold_count + HOLD_CYCLES;
		push_random(30);

		apply_settings(1'b0, SCALE_W'($urandom_range(24'hffffff)),
			SCALE_W'($urandom_range(24'hffffff)), 1'b1, 1'b1);
		repeat (8) begin
			case ($urandom_range(3))
				0: set_idle(0, 0);
				1: set_idle(IDLE_HEAVY, 0);
				2: set_idle(0, IDLE_HEAVY);
				default: set_idle(IDLE_LIGHT, IDLE_LIGHT);
			endcase
			push_random(15);
			while (rects_pending.size() != 0) @(negedge clk);
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && verts_predicted.size() == 0) begin
			$display("** anchored_quad_vertex_expander_core: PASSED **");
		end else begin
			$display("** anchored_quad_vertex_expander_core: FAILED **");
		end
		$finish;
	end

endmodule
